// ===== design/ccft_pkg.sv =====
// Package for the camera coordinate frame tracker: constants, codes and shared types.
// No dependencies. The parser, axis, speed and top modules use it.
`default_nettype none
package ccft_pkg;

  localparam int BUF_DEPTH  = 10;
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int MIN_FRAME  = 5;
  localparam int HIST_DEPTH = 4;

  localparam logic [7:0] HDR_A = 8'h2C;
  localparam logic [7:0] HDR_B = 8'h12;
  localparam logic [7:0] TERM  = 8'h5B;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN  = 2'd2;

  localparam logic [7:0]  JUMP_LIMIT_RST  = 8'd10;
  localparam logic [14:0] DELTA_LIMIT_RST = 15'd500;
  localparam logic [15:0] SPEED_GAIN_RST  = 16'd4845;

  localparam int POS_W = 15;
  localparam int SPD_W = 16;
  localparam int MAG_W = 31;

  // Division by 100 as multiply by ceil(2^29/100), exact for inputs below 2^22
  localparam int DIV_IN_W  = 22;
  localparam int DIV_MUL_W = 23;
  localparam int DIV_SHIFT = 29;
  localparam int DIV_PRD_W = DIV_IN_W + DIV_MUL_W;
  localparam logic [DIV_MUL_W-1:0] DIV100_MUL = 23'd5368710;

  localparam logic [SPD_W-1:0] Q_MAX_POS = 16'd32767;
  localparam logic [SPD_W-1:0] Q_MAX_NEG = 16'd32768;
  localparam logic signed [SPD_W-1:0] SPD_SAT_POS = 16'sh7FFF;
  localparam logic signed [SPD_W-1:0] SPD_SAT_NEG = 16'sh8000;

  typedef enum logic [3:0] {
    PS_HUNT    = 4'b0001,
    PS_HDR2    = 4'b0010,
    PS_PAYLOAD = 4'b0100,
    PS_TERM    = 4'b1000
  } parse_state_t;

  typedef struct packed {
    logic [7:0] x_int;
    logic [7:0] x_hund;
    logic [7:0] y_int;
    logic [7:0] y_hund;
  } coords_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic signed [SPD_W-1:0] delta;
    logic                    upd;
  } axis_res_t;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic v3;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ===== design/ccft_parser.sv =====
// Frame parser: header hunt, payload count, terminator check and coordinate latch.
// Depends on ccft_pkg.
`default_nettype none
module ccft_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire logic [7:0]        rx_byte,
  output      logic              latched,
  output      ccft_pkg::coords_t coords
);

  ccft_pkg::parse_state_t   state_r, state_nxt;
  logic [ccft_pkg::CNT_W-1:0] count_r, count_nxt, cnt_inc;
  logic [7:0]               hist_r [ccft_pkg::HIST_DEPTH];
  ccft_pkg::coords_t        coords_r;
  logic                     store, latch;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    store     = 1'b0;
    latch     = 1'b0;
    cnt_inc   = count_r + ccft_pkg::CNT_W'(1);
    unique case (state_r)
      ccft_pkg::PS_HUNT: begin
        if (rx_byte == ccft_pkg::HDR_A) begin
          state_nxt = ccft_pkg::PS_HDR2;
          store     = 1'b1;
          count_nxt = cnt_inc;
        end else begin
          count_nxt = '0;
        end
      end
      ccft_pkg::PS_HDR2: begin
        if (rx_byte == ccft_pkg::HDR_B) begin
          state_nxt = ccft_pkg::PS_PAYLOAD;
          store     = 1'b1;
          count_nxt = cnt_inc;
        end else begin
          state_nxt = ccft_pkg::PS_HUNT;
          count_nxt = '0;
        end
      end
      ccft_pkg::PS_PAYLOAD: begin
        store     = 1'b1;
        count_nxt = cnt_inc;
        if (cnt_inc >= ccft_pkg::CNT_W'(ccft_pkg::BUF_DEPTH) || rx_byte == ccft_pkg::TERM) begin
          state_nxt = ccft_pkg::PS_TERM;
          latch     = (cnt_inc >= ccft_pkg::CNT_W'(ccft_pkg::MIN_FRAME));
        end
      end
      ccft_pkg::PS_TERM: begin
        // restart the count; a header byte here opens the next frame
        if (rx_byte == ccft_pkg::HDR_A) begin
          state_nxt = ccft_pkg::PS_HDR2;
          store     = 1'b1;
          count_nxt = ccft_pkg::CNT_W'(1);
        end else begin
          state_nxt = ccft_pkg::PS_HUNT;
          count_nxt = '0;
        end
      end
      default: begin
        state_nxt = ccft_pkg::PS_HUNT;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ccft_pkg::PS_HUNT;
      count_r  <= '0;
      coords_r <= '0;
    end else if (byte_en) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (latch) begin
        coords_r.x_int  <= hist_r[3];
        coords_r.x_hund <= hist_r[2];
        coords_r.y_int  <= hist_r[1];
        coords_r.y_hund <= hist_r[0];
      end
    end
  end

  // last stored bytes, newest at index 0
  always_ff @(posedge clk) begin
    if (byte_en && store) begin
      hist_r[0] <= rx_byte;
      for (int i = 1; i < ccft_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  assign latched = byte_en && latch;
  assign coords  = coords_r;

endmodule
`default_nettype wire

// ===== design/ccft_axis.sv =====
// One axis of position tracking: jump rejection, position register and delta.
// Depends on ccft_pkg.
`default_nettype none
module ccft_axis (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       tick_en,
  input  wire logic [7:0]                 new_int,
  input  wire logic [7:0]                 new_hund,
  input  wire logic [7:0]                 jump_limit,
  input  wire logic [14:0]                delta_limit,
  output      ccft_pkg::axis_res_t        res
);

  logic [7:0]                 prev_int_r;
  logic [ccft_pkg::POS_W-1:0] pos_r, pos_nxt, new_pos;
  logic [7:0]                 jump;
  logic signed [ccft_pkg::SPD_W-1:0] delta;
  logic [ccft_pkg::POS_W-1:0] delta_abs;

  always_comb begin
    jump    = (prev_int_r >= new_int) ? (prev_int_r - new_int) : (new_int - prev_int_r);
    // int * 100 = int * 64 + int * 32 + int * 4
    new_pos = {1'b0, new_int, 6'b0} + {2'b0, new_int, 5'b0} + {5'b0, new_int, 2'b0}
              + {7'b0, new_hund};
    pos_nxt = (jump < jump_limit) ? new_pos : pos_r;
    delta   = $signed({1'b0, pos_nxt}) - $signed({1'b0, pos_r});
    delta_abs = delta[ccft_pkg::SPD_W-1] ? ccft_pkg::POS_W'(-delta)
                                         : delta[ccft_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_int_r <= '0;
      pos_r      <= '0;
    end else if (tick_en) begin
      prev_int_r <= new_int;
      pos_r      <= pos_nxt;
    end
  end

  assign res.pos   = tick_en ? pos_nxt : pos_r;
  assign res.delta = delta;
  assign res.upd   = tick_en && (delta_abs < delta_limit);

endmodule
`default_nettype wire

// ===== design/ccft_speed.sv =====
// Speed pipeline for one axis: delta times gain, divide by 100, saturate, hold.
// Depends on ccft_pkg; stage enables come from the top level.
`default_nettype none
module ccft_speed (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire ccft_pkg::pipe_ctl_t               ctl,
  input  wire logic signed [ccft_pkg::SPD_W-1:0] delta,
  input  wire logic                              upd,
  input  wire logic [15:0]                       gain,
  output      logic signed [ccft_pkg::SPD_W-1:0] speed
);

  logic [ccft_pkg::POS_W-1:0]     delta_abs;
  logic [ccft_pkg::MAG_W-1:0]     mag_r;
  logic                           neg2_r, upd2_r;
  logic [ccft_pkg::DIV_PRD_W-1:0] prod;
  logic [ccft_pkg::SPD_W-1:0]     q_r;
  logic                           big_r, neg3_r, upd3_r;
  logic signed [ccft_pkg::SPD_W-1:0] speed_r, speed_nxt;

  always_comb begin
    delta_abs = delta[ccft_pkg::SPD_W-1] ? ccft_pkg::POS_W'(-delta)
                                         : delta[ccft_pkg::POS_W-1:0];
    prod = ccft_pkg::DIV_PRD_W'(mag_r[ccft_pkg::DIV_IN_W-1:0])
           * ccft_pkg::DIV_PRD_W'(ccft_pkg::DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      mag_r  <= ccft_pkg::MAG_W'(delta_abs) * ccft_pkg::MAG_W'(gain);
      neg2_r <= delta[ccft_pkg::SPD_W-1];
      upd2_r <= upd;
    end
    if (ctl.en3) begin
      big_r  <= |mag_r[ccft_pkg::MAG_W-1:ccft_pkg::DIV_IN_W];
      q_r    <= prod[ccft_pkg::DIV_PRD_W-1:ccft_pkg::DIV_SHIFT];
      neg3_r <= neg2_r;
      upd3_r <= upd2_r;
    end
  end

  always_comb begin
    if (big_r) begin
      speed_nxt = neg3_r ? ccft_pkg::SPD_SAT_NEG : ccft_pkg::SPD_SAT_POS;
    end else if (!neg3_r) begin
      speed_nxt = (q_r > ccft_pkg::Q_MAX_POS) ? ccft_pkg::SPD_SAT_POS : $signed(q_r);
    end else begin
      speed_nxt = (q_r > ccft_pkg::Q_MAX_NEG) ? ccft_pkg::SPD_SAT_NEG
                                              : $signed(~q_r + ccft_pkg::SPD_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else if (ctl.en4 && ctl.v3 && upd3_r) begin
      speed_r <= speed_nxt;
    end
  end

  assign speed = speed_r;

endmodule
`default_nettype wire

// ===== design/camera_coordinate_frame_tracker.sv =====
// Camera coordinate frame tracker: input transfers pass through registered stages to result valid.
// Throughput one item per cycle while out_stall is low; speed multiply and divide-by-100 set the four stages.
// Synchronous active-low reset clears the parser, coordinates, positions, speeds,
// pipeline valids, and loads the register defaults (10, 500, 4845).
// Depends on ccft_pkg, ccft_parser, ccft_axis and ccft_speed.
`default_nettype none
module camera_coordinate_frame_tracker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic                               in_req_type,
  input  wire logic [7:0]                         in_rx_byte,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic                               out_frame_latched,
  output      logic [ccft_pkg::POS_W-1:0]         out_pos_x,
  output      logic [ccft_pkg::POS_W-1:0]         out_pos_y,
  output      logic signed [ccft_pkg::SPD_W-1:0]  out_speed_x,
  output      logic signed [ccft_pkg::SPD_W-1:0]  out_speed_y,
  input  wire logic                               cfg_we,
  input  wire logic [ccft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ccft_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  logic [7:0]  jump_limit_r;
  logic [14:0] delta_limit_r;
  logic [15:0] speed_gain_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  logic accept, byte_en, tick_en;
  ccft_pkg::pipe_ctl_t ctl;

  logic              latched;
  ccft_pkg::coords_t coords;
  ccft_pkg::axis_res_t res_x, res_y;

  logic                              lat1_r, lat2_r, lat3_r, lat4_r;
  logic [ccft_pkg::POS_W-1:0]        px1_r, px2_r, px3_r, px4_r;
  logic [ccft_pkg::POS_W-1:0]        py1_r, py2_r, py3_r, py4_r;
  logic signed [ccft_pkg::SPD_W-1:0] dx1_r, dy1_r;
  logic                              ux1_r, uy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_limit_r  <= ccft_pkg::JUMP_LIMIT_RST;
      delta_limit_r <= ccft_pkg::DELTA_LIMIT_RST;
      speed_gain_r  <= ccft_pkg::SPEED_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccft_pkg::CFG_JUMP_LIMIT:  jump_limit_r  <= cfg_wdata[7:0];
        ccft_pkg::CFG_DELTA_LIMIT: delta_limit_r <= cfg_wdata[14:0];
        ccft_pkg::CFG_SPEED_GAIN:  speed_gain_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance a stage when the next one is empty or advancing
  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;
  assign accept   = in_valid && en1;
  assign byte_en  = accept && (in_req_type == ccft_pkg::REQ_BYTE);
  assign tick_en  = accept && (in_req_type == ccft_pkg::REQ_TICK);

  assign ctl.en2 = en2;
  assign ctl.en3 = en3;
  assign ctl.en4 = en4;
  assign ctl.v3  = v3_r;

  ccft_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .rx_byte (in_rx_byte),
    .latched (latched),
    .coords  (coords)
  );

  ccft_axis u_axis_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (tick_en),
    .new_int     (coords.x_int),
    .new_hund    (coords.x_hund),
    .jump_limit  (jump_limit_r),
    .delta_limit (delta_limit_r),
    .res         (res_x)
  );

  ccft_axis u_axis_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_en     (tick_en),
    .new_int     (coords.y_int),
    .new_hund    (coords.y_hund),
    .jump_limit  (jump_limit_r),
    .delta_limit (delta_limit_r),
    .res         (res_y)
  );

  ccft_speed u_speed_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .delta (dx1_r),
    .upd   (ux1_r),
    .gain  (speed_gain_r),
    .speed (out_speed_x)
  );

  ccft_speed u_speed_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .delta (dy1_r),
    .upd   (uy1_r),
    .gain  (speed_gain_r),
    .speed (out_speed_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      lat1_r <= latched;
      px1_r  <= res_x.pos;
      py1_r  <= res_y.pos;
      dx1_r  <= res_x.delta;
      dy1_r  <= res_y.delta;
      ux1_r  <= res_x.upd;
      uy1_r  <= res_y.upd;
    end
    if (en2) begin
      lat2_r <= lat1_r;
      px2_r  <= px1_r;
      py2_r  <= py1_r;
    end
    if (en3) begin
      lat3_r <= lat2_r;
      px3_r  <= px2_r;
      py3_r  <= py2_r;
    end
    if (en4) begin
      lat4_r <= lat3_r;
      px4_r  <= px3_r;
      py4_r  <= py3_r;
    end
  end

  assign out_valid         = v4_r;
  assign out_frame_latched = lat4_r;
  assign out_pos_x         = px4_r;
  assign out_pos_y         = py4_r;

  a_tick_no_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type == ccft_pkg::REQ_TICK) |=> !lat1_r)
    else $error("tick transfer produced a frame latch");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && v4_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_no_update_on_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_req_type == ccft_pkg::REQ_BYTE) |=> (!ux1_r && !uy1_r))
    else $error("byte transfer requested a speed update");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for camera_coordinate_frame_tracker: directed table, then random frames, ticks and noise.
// Each result is checked against the table's gold row where given, else a cycle-free tracker predictor in this file.
// Depends on ccft_pkg and the camera_coordinate_frame_tracker RTL.
module tb;
  import ccft_pkg::*;

  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 216;
  localparam int MAX_GAP       = 18;
  localparam int LONG_HOLD     = 300;
  localparam int PRESSURE_LEN  = 60;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic                    latched;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [SPD_W-1:0] speed_x;
    logic signed [SPD_W-1:0] speed_y;
  } track_res_t;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic       gold_en;
    track_res_t gold;
  } dir_row_t;

  localparam track_res_t GOLD_ZERO  = '0;
  localparam track_res_t GOLD_LATCH = '{1'b1, 15'd0, 15'd0, 16'sd0, 16'sd0};

  localparam dir_row_t DIR_TAB [29] = '{
    '{REQ_TICK, 8'hFF, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, 8'h00, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, HDR_A, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, 8'h11, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, HDR_A, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, HDR_B, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, 8'h05, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, 8'h32, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, 8'h07, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, 8'h4B, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, TERM,  1'b1, GOLD_LATCH},
    '{REQ_BYTE, HDR_A, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, HDR_B, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, 8'h01, 1'b1, GOLD_ZERO},
    '{REQ_BYTE, TERM,  1'b1, GOLD_ZERO},
    '{REQ_TICK, 8'h00, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, HDR_A, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, HDR_B, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, 8'hFF, 1'b0, GOLD_ZERO},
    '{REQ_BYTE, TERM,  1'b0, GOLD_ZERO},
    '{REQ_TICK, 8'h00, 1'b0, GOLD_ZERO},
    '{REQ_TICK, 8'h00, 1'b0, GOLD_ZERO}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_req_type;
  logic [7:0]              in_rx_byte;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_frame_latched;
  logic [POS_W-1:0]        out_pos_x;
  logic [POS_W-1:0]        out_pos_y;
  logic signed [SPD_W-1:0] out_speed_x;
  logic signed [SPD_W-1:0] out_speed_y;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DAT_W-1:0]    cfg_wdata;

  logic       drv_gold_en;
  track_res_t drv_gold;

  camera_coordinate_frame_tracker u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_latched (out_frame_latched),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_speed_x       (out_speed_x),
    .out_speed_y       (out_speed_y),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Tracker predictor state
  logic [7:0]   trk_jump  = JUMP_LIMIT_RST;
  logic [14:0]  trk_delta = DELTA_LIMIT_RST;
  logic [15:0]  trk_gain  = SPEED_GAIN_RST;
  parse_state_t trk_state = PS_HUNT;
  int           trk_count = 0;
  logic [7:0]   trk_buf [BUF_DEPTH];
  logic [7:0]   trk_coords [4] = '{8'd0, 8'd0, 8'd0, 8'd0};
  logic [7:0]   trk_prev [2] = '{8'd0, 8'd0};
  int           trk_pos [2] = '{0, 0};
  int           trk_spd [2] = '{0, 0};

  track_res_t pending_results [$];
  int         n_sent    = 0;
  int         n_results = 0;
  int         n_err     = 0;
  int         cycle_cnt = 0;
  bit         in_burst  = 0;
  bit         out_burst = 0;
  bit         hold_req  = 0;
  int         gen_x     = 5;
  int         gen_y     = 7;

  function automatic void clear_frame();
    foreach (trk_buf[k]) trk_buf[k] = 8'd0;
    trk_count = 0;
    trk_state = PS_HUNT;
  endfunction

  function automatic void store_frame_byte(logic [7:0] b);
    if (trk_count < BUF_DEPTH) begin
      trk_buf[trk_count] = b;
      trk_count++;
    end
  endfunction

  function automatic logic parse_byte(logic [7:0] b);
    logic hit;
    logic good;
    hit = 1'b0;
    case (trk_state)
      PS_HUNT: begin
        if (b == HDR_A) begin
          trk_state = PS_HDR2;
          store_frame_byte(b);
        end else clear_frame();
      end
      PS_HDR2: begin
        if (b == HDR_B) begin
          trk_state = PS_PAYLOAD;
          store_frame_byte(b);
        end else clear_frame();
      end
      PS_PAYLOAD: begin
        store_frame_byte(b);
        if (trk_count >= BUF_DEPTH || b == TERM) begin
          trk_state = PS_TERM;
          if (trk_count >= MIN_FRAME) begin
            for (int k = 0; k < 4; k++) trk_coords[k] = trk_buf[trk_count - MIN_FRAME + k];
            hit = 1'b1;
          end
        end
      end
      default: begin
        good = (trk_count >= 1) && (trk_count <= BUF_DEPTH) && (trk_buf[trk_count-1] == TERM);
        if (good) begin
          trk_count = 0;
          trk_state = PS_HUNT;
        end else clear_frame();
        if (b == HDR_A) begin
          trk_state = PS_HDR2;
          store_frame_byte(b);
        end
      end
    endcase
    return hit;
  endfunction

  function automatic void axis_update(int ax, logic [7:0] new_int, logic [7:0] new_hund);
    int     old_pos;
    int     jump;
    int     delta;
    int     mag;
    longint prod;
    longint q;
    old_pos = trk_pos[ax];
    jump = int'(trk_prev[ax]) - int'(new_int);
    if (jump < 0) jump = -jump;
    if (jump < int'(trk_jump)) trk_pos[ax] = int'(new_int) * 100 + int'(new_hund);
    delta = trk_pos[ax] - old_pos;
    mag = (delta < 0) ? -delta : delta;
    if (mag < int'(trk_delta)) begin
      prod = longint'(delta) * longint'(trk_gain);
      q = prod / 100;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      trk_spd[ax] = int'(q);
    end
    trk_prev[ax] = new_int;
  endfunction

  function automatic track_res_t tracker_predict(logic req, logic [7:0] b);
    track_res_t r;
    r.latched = 1'b0;
    if (req == REQ_BYTE) begin
      r.latched = parse_byte(b);
    end else begin
      axis_update(0, trk_coords[0], trk_coords[1]);
      axis_update(1, trk_coords[2], trk_coords[3]);
    end
    r.pos_x   = POS_W'(trk_pos[0]);
    r.pos_y   = POS_W'(trk_pos[1]);
    r.speed_x = SPD_W'(trk_spd[0]);
    r.speed_y = SPD_W'(trk_spd[1]);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("camera_coordinate_frame_tracker test failed");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    track_res_t want;
    track_res_t got;
    if (rst_n && in_valid && !in_stall) begin
      want = tracker_predict(in_req_type, in_rx_byte);
      pending_results.push_back(drv_gold_en ? drv_gold : want);
    end
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      got = '{out_frame_latched, out_pos_x, out_pos_y, out_speed_x, out_speed_y};
      if (pending_results.size() == 0) begin
        if (n_err < REPORT_MAX) $display("result %0d with nothing expected", n_results);
        n_err++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (n_err < REPORT_MAX)
            $display("result %0d: exp latched=%0d px=%0d py=%0d sx=%0d sy=%0d, got latched=%0d px=%0d py=%0d sx=%0d sy=%0d",
                     n_results, want.latched, want.pos_x, want.pos_y, want.speed_x, want.speed_y,
                     got.latched, got.pos_x, got.pos_y, got.speed_x, got.speed_y);
          n_err++;
        end
      end
    end
  end

  // Receiver: random stall per transfer, with an occasional long hold-off
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        n = LONG_HOLD;
      end else begin
        n = out_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      repeat (n) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(logic req, logic [7:0] b, logic gold_en, track_res_t gold);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= b;
    drv_gold_en <= gold_en;
    drv_gold    <= gold;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_BYTE, b, 1'b0, GOLD_ZERO);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, GOLD_ZERO);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_JUMP_LIMIT:  trk_jump  = val[7:0];
      CFG_DELTA_LIMIT: trk_delta = val[14:0];
      CFG_SPEED_GAIN:  trk_gain  = val;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (n_results < n_sent) @(posedge clk);
  endtask

  function automatic int next_coord(int cur);
    int span;
    int v;
    if ($urandom_range(0, 5) == 0) span = 2 * int'(trk_jump) + 4;
    else span = (trk_jump > 1) ? int'(trk_jump) - 1 : 0;
    if (span > 255) span = 255;
    v = cur + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic logic [7:0] rand_hund();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 99));
  endfunction

  // Header, payload with coordinates, then TERM or a full buffer without TERM
  task automatic send_frame(int pad, logic full_len);
    logic [7:0] xh;
    logic [7:0] yh;
    gen_x = next_coord(gen_x);
    gen_y = next_coord(gen_y);
    xh = rand_hund();
    yh = rand_hund();
    send_byte(HDR_A);
    send_byte(HDR_B);
    repeat (full_len ? 3 : pad) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'(gen_x));
    send_byte(xh);
    send_byte(8'(gen_y));
    send_byte(yh);
    send_byte(full_len ? 8'($urandom_range(0, 255)) : TERM);
    if (full_len || $urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin : stimulus
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_BYTE;
    in_rx_byte  <= 8'd0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_JUMP_LIMIT;
    cfg_wdata   <= '0;
    drv_gold_en <= 1'b0;
    drv_gold    <= GOLD_ZERO;
    foreach (trk_buf[k]) trk_buf[k] = 8'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        in_valid <= 1'b0;
        wait_idle();
        case (phase)
          1: begin
            write_reg(CFG_JUMP_LIMIT, 16'd255);
            write_reg(CFG_DELTA_LIMIT, 16'd25755);
            write_reg(CFG_SPEED_GAIN, 16'hFFFF);
          end
          2: begin
            write_reg(CFG_JUMP_LIMIT, 16'd1);
            write_reg(CFG_DELTA_LIMIT, 16'd1);
            write_reg(CFG_SPEED_GAIN, 16'd0);
            write_reg(CFG_UNMAPPED, 16'hFFFF);
          end
          4: begin
            write_reg(CFG_JUMP_LIMIT, 16'd40);
            write_reg(CFG_DELTA_LIMIT, 16'd3000);
            write_reg(CFG_SPEED_GAIN, 16'd4845);
          end
          default: begin
            write_reg(CFG_JUMP_LIMIT, 16'($urandom_range(1, 255)));
            write_reg(CFG_DELTA_LIMIT, 16'($urandom_range(1, 25755)));
            write_reg(CFG_SPEED_GAIN, 16'($urandom_range(0, 65535)));
          end
        endcase
      end

      if (phase == 0) begin
        for (int i = 0; i < $size(DIR_TAB); i++)
          send_item(DIR_TAB[i].req, DIR_TAB[i].data, DIR_TAB[i].gold_en, DIR_TAB[i].gold);
      end

      if (phase == 4) begin
        hold_req = 1;
        in_burst = 1;
        repeat (PRESSURE_LEN / 10) begin
          send_frame($urandom_range(0, 3), 1'b0);
          send_tick();
        end
      end

      while (n_sent < (phase + 1) * PHASE_ITEMS) begin
        in_burst = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            send_frame($urandom_range(0, 3), 1'b0);
            repeat ($urandom_range(1, 2)) send_tick();
          end
          4: begin
            send_frame(0, 1'b1);
            send_tick();
          end
          5: repeat ($urandom_range(1, 3)) send_tick();
          6: repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
          7: begin
            send_byte(HDR_A);
            send_byte(8'($urandom_range(0, 255)));
          end
          8: begin
            send_byte(HDR_A);
            send_byte(HDR_B);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
            send_byte(TERM);
            send_tick();
          end
          default: begin
            send_frame($urandom_range(0, 3), 1'b0);
            send_byte(8'($urandom_range(0, 255)));
            send_tick();
          end
        endcase
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("camera_coordinate_frame_tracker test passed");
    end else begin
      $display("camera_coordinate_frame_tracker test failed");
    end
    $finish;
  end

endmodule

// ===== camera_coordinate_frame_tracker.f =====
design/ccft_pkg.sv
design/ccft_parser.sv
design/ccft_axis.sv
design/ccft_speed.sv
design/camera_coordinate_frame_tracker.sv
tb/sv/tb.sv
